[rtl/hcd_pkg.sv]
package hcd_pkg;

   localparam int MIN_SIZE   = 5;
   localparam int HEIGHT_CAP = 4096;
   localparam int DIM_W      = 13;
   localparam int ROW_W      = 13;
   localparam int CALC_W     = 14;

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_HARRIS_K     = 2'd2;
   localparam logic [1:0] REG_THRESHOLD    = 2'd3;

   typedef struct packed {
      logic [7:0] pixel;
      logic       grad_ok;
      logic       emit;
      logic       corner_ok;
      logic       last;
   } hcd_item_type;

   typedef struct packed {
      logic signed [20:0] xy;
      logic [20:0]        yy;
      logic [20:0]        xx;
   } hcd_prod_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } hcd_geom_type;

   typedef struct packed {
      logic [15:0] k;
      logic [47:0] threshold;
   } hcd_score_type;

endpackage

[rtl/hcd_ram.sv]
module hcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hcd_fifo.sv]
module hcd_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/hcd_front.sv]
module hcd_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hcd_pkg::hcd_geom_type        geom,
   input  logic                         in_valid,
   input  logic                         in_action,
   input  logic [7:0]                   in_pixel,
   output logic                         in_ready,
   input  logic                         q_full,
   output logic                         q_push,
   output hcd_pkg::hcd_item_type        q_item,
   output logic [$clog2(MAX_WIDTH)-1:0] q_col,
   output logic [$clog2(MAX_WIDTH)-1:0] q_gc
);
   import hcd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CALC_W-1:0] w, h, row_x, col_x, orow, ocol;
   logic              accept, last, emit;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign q_push   = accept;

   always_comb begin
      if (geom.width < DIM_W'(MIN_SIZE)) begin
         w = CALC_W'(MIN_SIZE);
      end else if (CALC_W'(geom.width) > CALC_W'(MAX_WIDTH)) begin
         w = CALC_W'(MAX_WIDTH);
      end else begin
         w = CALC_W'(geom.width);
      end
      if (geom.height < DIM_W'(MIN_SIZE)) begin
         h = CALC_W'(MIN_SIZE);
      end else if (CALC_W'(geom.height) > CALC_W'(HEIGHT_CAP)) begin
         h = CALC_W'(HEIGHT_CAP);
      end else begin
         h = CALC_W'(geom.height);
      end
      row_x = CALC_W'(row_ff);
      col_x = CALC_W'(col_ff);

      last = (row_x >= h + CALC_W'(3)) && (col_x >= CALC_W'(2));
      emit = (row_x > CALC_W'(3)) || ((row_x == CALC_W'(3)) && (col_x >= CALC_W'(3)));
      if (col_x >= CALC_W'(3)) begin
         orow = row_x - CALC_W'(3);
         ocol = col_x - CALC_W'(3);
      end else begin
         orow = row_x - CALC_W'(4);
         ocol = w - CALC_W'(3) + col_x;
      end

      q_item.pixel     = (!in_action && (row_x < h)) ? in_pixel : 8'd0;
      q_item.grad_ok   = (col_x >= CALC_W'(2)) && (col_x + CALC_W'(1) <= w)
                         && (row_x >= CALC_W'(2)) && (row_x + CALC_W'(1) <= h);
      q_item.emit      = emit;
      q_item.corner_ok = emit && (orow >= CALC_W'(2)) && (orow + CALC_W'(3) <= h)
                         && (ocol >= CALC_W'(2)) && (ocol + CALC_W'(3) <= w);
      q_item.last      = last;
      q_col            = col_ff;
      q_gc             = (col_x >= CALC_W'(1)) ? COL_W'(col_x - CALC_W'(1))
                                               : COL_W'(w - CALC_W'(1));

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_x + CALC_W'(1) >= w) begin
            row_in = ROW_W'(row_x + CALC_W'(1));
            col_in = '0;
         end else begin
            col_in = COL_W'(col_x + CALC_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

[rtl/hcd_back.sv]
module hcd_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hcd_pkg::hcd_score_type       score,
   input  logic                         q_empty,
   input  hcd_pkg::hcd_item_type        q_item,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_gc,
   output logic                         q_pop,
   output logic                         rsp_valid,
   output logic                         rsp_corner,
   output logic                         rsp_last,
   input  logic                         rsp_ready
);
   import hcd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_GRAD = 8'b0000_0010,
      ST_PROD = 8'b0000_0100,
      ST_COL  = 8'b0000_1000,
      ST_BOX  = 8'b0001_0000,
      ST_MUL  = 8'b0010_0000,
      ST_MUL2 = 8'b0100_0000,
      ST_CMP  = 8'b1000_0000
   } hcd_state_type;

   hcd_state_type state_ff, state_in;

   hcd_item_type     cur_ff;
   logic [COL_W-1:0] col_ff, gc_ff;

   logic [7:0] win_ff [3][3];
   logic [7:0] top_px, mid_px;
   logic [9:0] sum_a, sum_b, sum_c, sum_d;
   logic signed [10:0] gx, gy;
   logic signed [10:0] gx_ff, gy_ff;
   hcd_prod_type       p_ff;
   logic signed [21:0] pxx, pyy, pxy;

   hcd_prod_type  line_rd [4];
   hcd_prod_type  line_wr [4];
   logic          pl_wr, pr_wr, rd_en;

   logic [22:0]        cxx_ff [5];
   logic [22:0]        cyy_ff [5];
   logic signed [23:0] cxy_ff [5];
   logic [22:0]        nxx, nyy;
   logic signed [23:0] nxy;

   logic [24:0]        sxx_ff, syy_ff;
   logic signed [25:0] sxy_ff;
   logic [49:0]        a_ff;
   logic signed [51:0] b_ff;
   logic [51:0]        t2_ff;
   logic [25:0]        tr;
   logic signed [50:0] det_ff;
   logic [41:0]        lo_ff, hi_ff;
   logic [69:0]        lhs, rhs;
   logic               corner;

   logic rsp_valid_ff, rsp_corner_ff, rsp_last_ff;
   logic load_out;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign rd_en = q_pop;

   hcd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_pix_top (
      .clock(clock), .wr_en(pl_wr), .wr_addr(col_ff), .wr_data(mid_px),
      .rd_en(rd_en), .rd_addr(q_col), .rd_data(top_px));
   hcd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_pix_mid (
      .clock(clock), .wr_en(pl_wr), .wr_addr(col_ff), .wr_data(cur_ff.pixel),
      .rd_en(rd_en), .rd_addr(q_col), .rd_data(mid_px));

   for (genvar i = 0; i < 4; i++) begin : g_prod_line
      hcd_ram #(.WIDTH($bits(hcd_prod_type)), .DEPTH(MAX_WIDTH)) u_prod (
         .clock(clock), .wr_en(pr_wr), .wr_addr(gc_ff), .wr_data(line_wr[i]),
         .rd_en(rd_en), .rd_addr(q_gc), .rd_data(line_rd[i]));
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         line_wr[i] = line_rd[i+1];
      end
      line_wr[3] = p_ff;
   end

   assign pl_wr = (state_ff == ST_GRAD);
   assign pr_wr = (state_ff == ST_COL);

   // Sobel on the shifted window: old columns 1 and 2, then the new column
   always_comb begin
      sum_a = 10'(win_ff[0][1]) + {1'b0, win_ff[0][2], 1'b0} + 10'(top_px);
      sum_b = 10'(win_ff[2][1]) + {1'b0, win_ff[2][2], 1'b0} + 10'(cur_ff.pixel);
      sum_c = 10'(top_px) + {1'b0, mid_px, 1'b0} + 10'(cur_ff.pixel);
      sum_d = 10'(win_ff[0][1]) + {1'b0, win_ff[1][1], 1'b0} + 10'(win_ff[2][1]);
      gx = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});
      gy = $signed({1'b0, sum_c}) - $signed({1'b0, sum_d});
      pxx = gx_ff * gx_ff;
      pyy = gy_ff * gy_ff;
      pxy = gx_ff * gy_ff;
   end

   always_comb begin
      nxx = 23'(p_ff.xx);
      nyy = 23'(p_ff.yy);
      nxy = 24'(p_ff.xy);
      for (int i = 0; i < 4; i++) begin
         nxx = nxx + 23'(line_rd[i].xx);
         nyy = nyy + 23'(line_rd[i].yy);
         nxy = nxy + 24'(line_rd[i].xy);
      end
   end

   always_comb begin
      tr     = 26'(sxx_ff) + 26'(syy_ff);
      lhs    = {4'd0, det_ff[49:0], 16'd0};
      rhs    = {2'd0, hi_ff, 26'd0} + 70'(lo_ff) + 70'(score.threshold);
      corner = !det_ff[50] && (lhs > rhs);
   end

   assign load_out = (state_ff == ST_CMP) && cur_ff.emit && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_GRAD;
         ST_GRAD: state_in = ST_PROD;
         ST_PROD: state_in = ST_COL;
         ST_COL:  state_in = ST_BOX;
         ST_BOX:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_CMP;
         ST_CMP:  if (!cur_ff.emit || load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= 8'd0;
            end
         end
         for (int i = 0; i < 5; i++) begin
            cxx_ff[i] <= '0;
            cyy_ff[i] <= '0;
            cxy_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_GRAD) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= top_px;
            win_ff[1][2] <= mid_px;
            win_ff[2][2] <= cur_ff.pixel;
         end
         if (state_ff == ST_COL) begin
            for (int i = 0; i < 4; i++) begin
               cxx_ff[i] <= cxx_ff[i+1];
               cyy_ff[i] <= cyy_ff[i+1];
               cxy_ff[i] <= cxy_ff[i+1];
            end
            cxx_ff[4] <= nxx;
            cyy_ff[4] <= nyy;
            cxy_ff[4] <= nxy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
         col_ff <= q_col;
         gc_ff  <= q_gc;
      end
      if (state_ff == ST_GRAD) begin
         gx_ff <= cur_ff.grad_ok ? gx : 11'sd0;
         gy_ff <= cur_ff.grad_ok ? gy : 11'sd0;
      end
      if (state_ff == ST_PROD) begin
         p_ff.xx <= pxx[20:0];
         p_ff.yy <= pyy[20:0];
         p_ff.xy <= pxy[20:0];
      end
      if (state_ff == ST_BOX) begin
         sxx_ff <= 25'(cxx_ff[0]) + 25'(cxx_ff[1]) + 25'(cxx_ff[2])
                   + 25'(cxx_ff[3]) + 25'(cxx_ff[4]);
         syy_ff <= 25'(cyy_ff[0]) + 25'(cyy_ff[1]) + 25'(cyy_ff[2])
                   + 25'(cyy_ff[3]) + 25'(cyy_ff[4]);
         sxy_ff <= 26'(cxy_ff[0]) + 26'(cxy_ff[1]) + 26'(cxy_ff[2])
                   + 26'(cxy_ff[3]) + 26'(cxy_ff[4]);
      end
      if (state_ff == ST_MUL) begin
         a_ff  <= sxx_ff * syy_ff;
         b_ff  <= sxy_ff * sxy_ff;
         t2_ff <= tr * tr;
      end
      if (state_ff == ST_MUL2) begin
         det_ff <= $signed({1'b0, a_ff}) - b_ff[50:0];
         lo_ff  <= t2_ff[25:0] * score.k;
         hi_ff  <= t2_ff[51:26] * score.k;
      end
      if (load_out) begin
         rsp_corner_ff <= cur_ff.corner_ok && corner;
         rsp_last_ff   <= cur_ff.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_corner = rsp_corner_ff;
   assign rsp_last   = rsp_last_ff;

   a_out_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CMP))
      else $error("result loaded outside compare step");

   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_GRAD))
      else $error("queue pop did not start an item");

   a_corner_needs_window: assert property (@(posedge clock) disable iff (reset)
      (load_out && !cur_ff.corner_ok) |=> !rsp_corner_ff)
      else $error("corner flagged on border pixel");

endmodule

[rtl/harris_corner_detector.sv]
// channel | ports                       | payload
// req     | req_tvalid/tready/tdata/user | tdata[7:0] pixel, tuser action
// rsp     | rsp_tvalid/tready/tdata/last | tdata[0] is_corner, tlast last_of_frame
// csr     | csr_wr_en/index/wr_data      | 0 width, 1 height, 2 k, 3 threshold
// The back-end sequencer takes one item at a time (read, gradient, product,
// column sum, box sum, two multiply steps, compare) and sets the rate.
// A two-entry queue lets the front accept items while the back works.
// Synchronous reset clears counters, windows and the queue; line memories
// are not cleared. The result register holds until rsp_tready.
module harris_corner_detector #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // is_corner, zero fill
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wr_data
);
   import hcd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int Q_W   = $bits(hcd_item_type) + 2 * COL_W;

   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [15:0] harris_k_ff;
   logic [47:0] threshold_ff;

   hcd_geom_type  geom;
   hcd_score_type score;
   hcd_item_type  f_item, b_item;
   logic [COL_W-1:0] f_col, f_gc, b_col, b_gc;
   logic [Q_W-1:0]   q_in, q_head;
   logic q_push, q_pop, q_full, q_empty, rsp_corner;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd512;
         frame_height_ff <= 13'd512;
         harris_k_ff     <= 16'd3277;
         threshold_ff    <= 48'd409600;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data[10:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wr_data[12:0];
            REG_HARRIS_K:     harris_k_ff     <= csr_wr_data[15:0];
            REG_THRESHOLD:    threshold_ff    <= csr_wr_data;
            default:          threshold_ff    <= threshold_ff;
         endcase
      end
   end

   assign geom.width      = DIM_W'(frame_width_ff);
   assign geom.height     = frame_height_ff;
   assign score.k         = harris_k_ff;
   assign score.threshold = threshold_ff;

   hcd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock), .reset(reset), .geom(geom),
      .in_valid(req_tvalid), .in_action(req_tuser), .in_pixel(req_tdata),
      .in_ready(req_tready), .q_full(q_full), .q_push(q_push),
      .q_item(f_item), .q_col(f_col), .q_gc(f_gc));

   assign q_in = {f_gc, f_col, f_item};
   assign {b_gc, b_col, b_item} = q_head;

   hcd_fifo #(.WIDTH(Q_W)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head));

   hcd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock(clock), .reset(reset), .score(score),
      .q_empty(q_empty), .q_item(b_item), .q_col(b_col), .q_gc(b_gc),
      .q_pop(q_pop), .rsp_valid(rsp_tvalid), .rsp_corner(rsp_corner),
      .rsp_last(rsp_tlast), .rsp_ready(rsp_tready));

   assign rsp_tdata = {7'd0, rsp_corner};

endmodule

[dv/tb_harris_corner_detector.sv]
module tb_harris_corner_detector;
   timeunit 1ns;
   timeprecision 1ps;
   import hcd_pkg::*;

   localparam int MAXW = 1024;
   localparam int STALL_LIMIT = 2000;

   class corner_predictor;
      bit [7:0]     pix_line[2][MAXW];
      hcd_prod_type prod_line[4][MAXW];
      bit [7:0]     pwin[3][3];
      hcd_prod_type gwin[5][5];
      int unsigned  row, col;
      int unsigned  width_reg, height_reg, k_reg;
      bit [47:0]    thr_reg;
      bit [1:0]     expected_marks[$];
      int           errors;

      function new();
         row = 0;
         col = 0;
         width_reg = 512;
         height_reg = 512;
         k_reg = 3277;
         thr_reg = 48'd409600;
         errors = 0;
         foreach (pwin[r, c]) pwin[r][c] = 0;
         foreach (gwin[r, c]) gwin[r][c] = '0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [47:0] val);
         case (idx)
            REG_FRAME_WIDTH:  width_reg = val[10:0];
            REG_FRAME_HEIGHT: height_reg = val[12:0];
            REG_HARRIS_K:     k_reg = val[15:0];
            REG_THRESHOLD:    thr_reg = val;
         endcase
      endfunction

      function int unsigned width_used();
         return (width_reg < MIN_SIZE) ? MIN_SIZE : (width_reg > MAXW) ? MAXW : width_reg;
      endfunction

      function int unsigned height_used();
         return (height_reg < MIN_SIZE) ? MIN_SIZE :
                (height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg;
      endfunction

      function bit window_corner();
         longint sxx, syy, sxy, det, tr;
         logic [127:0] lhs, rhs;
         sxx = 0;
         syy = 0;
         sxy = 0;
         foreach (gwin[r, c]) begin
            sxx += longint'(gwin[r][c].xx);
            syy += longint'(gwin[r][c].yy);
            sxy += longint'(gwin[r][c].xy);
         end
         det = sxx * syy - sxy * sxy;
         if (det < 0) return 0;
         tr = sxx + syy;
         lhs = 128'(det) << 16;
         rhs = 128'(tr * tr) * 128'(k_reg) + 128'(thr_reg);
         return lhs > rhs;
      endfunction

      function void take_pixel(bit action, bit [7:0] px);
         int unsigned w, h, r0, c0, gc, orow, ocol;
         bit [7:0] pix, top, mid;
         int gx, gy;
         hcd_prod_type p, colv[5];
         bit last, corner;
         w = width_used();
         h = height_used();
         r0 = row;
         c0 = (col >= MAXW) ? 0 : col;
         pix = (!action && r0 < h) ? px : 8'd0;
         top = pix_line[0][c0];
         mid = pix_line[1][c0];
         pix_line[0][c0] = mid;
         pix_line[1][c0] = pix;
         for (int r = 0; r < 3; r++) begin
            pwin[r][0] = pwin[r][1];
            pwin[r][1] = pwin[r][2];
         end
         pwin[0][2] = top;
         pwin[1][2] = mid;
         pwin[2][2] = pix;
         p = '0;
         gc = (c0 >= 1) ? c0 - 1 : w - 1;
         if (c0 >= 2 && c0 + 1 <= w && r0 >= 2 && r0 + 1 <= h) begin
            gx = (pwin[0][0] + 2 * pwin[0][1] + pwin[0][2])
               - (pwin[2][0] + 2 * pwin[2][1] + pwin[2][2]);
            gy = (pwin[0][2] + 2 * pwin[1][2] + pwin[2][2])
               - (pwin[0][0] + 2 * pwin[1][0] + pwin[2][0]);
            p.xx = gx * gx;
            p.yy = gy * gy;
            p.xy = gx * gy;
         end
         if (gc >= MAXW) gc = 0;
         for (int k = 0; k < 4; k++) colv[k] = prod_line[k][gc];
         colv[4] = p;
         for (int k = 0; k < 3; k++) prod_line[k][gc] = prod_line[k + 1][gc];
         prod_line[3][gc] = p;
         for (int r = 0; r < 5; r++) begin
            for (int k = 0; k < 4; k++) gwin[r][k] = gwin[r][k + 1];
            gwin[r][4] = colv[r];
         end
         last = (r0 >= h + 3 && c0 >= 2);
         if (r0 > 3 || (r0 == 3 && c0 >= 3)) begin
            if (c0 >= 3) begin
               orow = r0 - 3;
               ocol = c0 - 3;
            end else begin
               orow = r0 - 4;
               ocol = w - 3 + c0;
            end
            corner = 0;
            if (orow >= 2 && orow + 3 <= h && ocol >= 2 && ocol + 3 <= w)
               corner = window_corner();
            expected_marks.push_back({last, corner});
         end
         if (last) begin
            row = 0;
            col = 0;
         end else if (c0 + 1 >= w) begin
            col = 0;
            row = r0 + 1;
         end else begin
            col = c0 + 1;
            row = r0;
         end
      endfunction

      function void match_mark(bit [7:0] data, bit last);
         bit [1:0] m;
         if (expected_marks.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: data=%0h last=%0b", data, last);
            return;
         end
         m = expected_marks.pop_front();
         if (data !== {7'b0, m[0]} || last !== m[1]) begin
            errors++;
            if (errors <= 10)
               $display("result wrong: expected corner=%0b last=%0b, got data=%0h last=%0b",
                        m[0], m[1], data, last);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 0;
   logic [1:0]  csr_index = REG_FRAME_WIDTH;
   logic [47:0] csr_wr_data = 0;

   corner_predictor sb = new();
   bit quiet = 0;
   int rsp_hold = 0;
   int idle_cycles = 0;
   int rand_items = 0;

   harris_corner_detector dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.take_pixel(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.match_mark(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_tready <= 1;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 0;
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         rsp_hold <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("harris_corner_detector: mismatch");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [47:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_wr_en <= 0;
   endtask

   task automatic send_item(bit action, bit [7:0] px);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= action;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_wait();
      req_tvalid <= 0;
      while (sb.expected_marks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // style: 0 noise, 1 checker blocks, 2 lone square, 3 flat
   task automatic send_frame(int style, bit noisy, bit mid_pause);
      int unsigned w, h, bs, sx, sy, x, y;
      bit [7:0] lo, hi, px;
      bit action;
      w = sb.width_used();
      h = sb.height_used();
      bs = $urandom_range(1, 4);
      lo = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      hi = $urandom_range(0, 1) ? 8'd255 : 8'($urandom);
      sx = $urandom_range(0, w - 1);
      sy = $urandom_range(0, h - 1);
      for (int unsigned i = 0; i < w * h + 3 * w + 3; i++) begin
         x = i % w;
         y = i / w;
         case (style)
            0: px = 8'($urandom);
            1: px = (((x / bs) + (y / bs)) & 1) ? hi : lo;
            2: px = (x >= sx && x < sx + bs + 1 && y >= sy && y < sy + bs + 1) ? hi : lo;
            default: px = lo;
         endcase
         if (i < w * h) action = noisy && $urandom_range(0, 19) == 0;
         else action = !(noisy && $urandom_range(0, 4) == 0);
         if (mid_pause && i == w * h / 2) drain_wait();
         send_item(action, px);
         rand_items++;
      end
      drain_wait();
   endtask

   initial begin
      bit [47:0] thr;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_reg(REG_FRAME_WIDTH, 48'd5);
      write_reg(REG_FRAME_HEIGHT, 48'd5);
      write_reg(REG_HARRIS_K, 48'd0);
      write_reg(REG_THRESHOLD, 48'd0);
      send_frame(1, 1, 1);
      rand_items = 0;

      while (rand_items < 540) begin
         case ($urandom_range(0, 5))
            0: write_reg(REG_FRAME_WIDTH, 48'($urandom_range(0, 4)));
            1: write_reg(REG_FRAME_WIDTH, 48'($urandom_range(17, 24)));
            default: write_reg(REG_FRAME_WIDTH, 48'($urandom_range(5, 16)));
         endcase
         if ($urandom_range(0, 4) == 0) write_reg(REG_FRAME_HEIGHT, 48'($urandom_range(0, 4)));
         else write_reg(REG_FRAME_HEIGHT, 48'($urandom_range(5, 12)));
         case ($urandom_range(0, 3))
            0: write_reg(REG_HARRIS_K, 48'd65535);
            1: write_reg(REG_HARRIS_K, 48'($urandom_range(0, 65535)));
            default: write_reg(REG_HARRIS_K, 48'($urandom_range(0, 8000)));
         endcase
         case ($urandom_range(0, 4))
            0: thr = '1;
            1: thr = 48'({$urandom, $urandom});
            2: thr = 48'($urandom) << $urandom_range(0, 16);
            default: thr = 48'($urandom_range(0, 1 << 20));
         endcase
         write_reg(REG_THRESHOLD, thr);
         send_frame($urandom_range(0, 3), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 5) == 0);
      end

      quiet = 1;
      write_reg(REG_FRAME_WIDTH, 48'd7);
      write_reg(REG_FRAME_HEIGHT, 48'd6);
      write_reg(REG_HARRIS_K, 48'd3277);
      write_reg(REG_THRESHOLD, 48'd409600);
      send_frame(1, 0, 0);

      req_tvalid <= 0;
      while (sb.expected_marks.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.expected_marks.size() == 0)
         $display("harris_corner_detector: match");
      else
         $display("harris_corner_detector: mismatch");
      $finish;
   end
endmodule
